@@ hw/rtl/midi_rsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Message kind codes, status byte constants and small field widths.
// ----------------------------------------------------------------------------
package midi_rsp_pkg;

  // Decoded message kinds
  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_PRESSURE = 3'd2;
  localparam logic [2:0] KIND_CONTROL  = 3'd3;
  localparam logic [2:0] KIND_PROGRAM  = 3'd4;
  localparam logic [2:0] KIND_BEND     = 3'd5;

  // Status byte values
  localparam logic [7:0] ST_REALTIME   = 8'hF8;
  localparam logic [7:0] ST_SYSEX_SOX  = 8'hF0;
  localparam logic [7:0] ST_SYSEX_EOX  = 8'hF7;

  // High nibbles of channel status bytes
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_POLY_AT    = 4'hA;
  localparam logic [3:0] HI_CONTROL    = 4'hB;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_CHAN_AT    = 4'hD;

  typedef logic [6:0] data7_t;

endpackage
`default_nettype wire

@@ hw/rtl/midi_running_status_parser_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI running-status parser core
// Parses a MIDI byte stream into decoded channel messages.
// ----------------------------------------------------------------------------
// Usage:
//   in_rx_byte carries one raw MIDI byte per request on the in_ channel.
//   Decoded channel messages leave on the out_ channel as kind, channel,
//   number and amount. Realtime bytes, SysEx contents and status-only bytes
//   produce no result; a completed message produces exactly one.
//   The byte is captured in an input register; once the result register can
//   take a new value, the parse logic updates the running status, data buffer
//   and SysEx flag and loads the result register. A result thus passes
//   through the input register and then the result register.
//   Throughput is one byte per cycle: the input register is drained in every
//   cycle in which the result register is empty or being taken.
//   When the receiver stalls with a result pending, one more byte is held in
//   the input register and in_ready drops until the result is taken.
//   Synchronous reset (rst_n low) clears running status, data count, the
//   SysEx flag and both valid flags.
// ----------------------------------------------------------------------------
module midi_running_status_parser_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_msg_kind,
  output logic [3:0]      out_channel,
  output logic [6:0]      out_number,
  output logic [13:0]     out_amount
);

  // Input register
  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;

  // Parser state
  logic [7:0]               status_r, status_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  midi_rsp_pkg::data7_t     d0_r, d0_nxt, d1_r, d1_nxt;
  logic                     sysex_r, sysex_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  chan_r, chan_nxt;
  logic [6:0]  num_r, num_nxt;
  logic [13:0] amt_r, amt_nxt;

  logic       adv;
  logic       emit;
  logic [1:0] needed;
  logic [3:0] hi;

  // Advance the held byte when the result register can take a new value
  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_ready ? in_valid : in_valid_r;
  end

  // Parse one byte
  always_comb begin
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    d0_nxt     = d0_r;
    d1_nxt     = d1_r;
    sysex_nxt  = sysex_r;
    emit       = 1'b0;
    kind_nxt   = midi_rsp_pkg::KIND_NOTE_OFF;
    num_nxt    = 7'd0;
    amt_nxt    = 14'd0;
    hi         = status_r[7:4];
    chan_nxt   = status_r[3:0];
    needed     = (hi == midi_rsp_pkg::HI_PROGRAM || hi == midi_rsp_pkg::HI_CHAN_AT)
                 ? 2'd1 : 2'd2;
    if (in_byte_r >= midi_rsp_pkg::ST_REALTIME) begin
      // drop realtime bytes
    end else if (in_byte_r[7]) begin
      if (in_byte_r == midi_rsp_pkg::ST_SYSEX_SOX) begin
        sysex_nxt = 1'b1;
      end else if (in_byte_r == midi_rsp_pkg::ST_SYSEX_EOX) begin
        sysex_nxt = 1'b0;
      end else if (in_byte_r > midi_rsp_pkg::ST_SYSEX_SOX) begin
        status_nxt = 8'd0;
        cnt_nxt    = 2'd0;
      end else begin
        status_nxt = in_byte_r;
        cnt_nxt    = 2'd0;
      end
    end else if (!sysex_r && status_r[7]) begin
      // Collect data byte
      if (cnt_r < 2'd2) begin
        if (cnt_r[0]) begin
          d1_nxt = in_byte_r[6:0];
        end else begin
          d0_nxt = in_byte_r[6:0];
        end
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        d0_nxt  = in_byte_r[6:0];
        cnt_nxt = 2'd1;
      end
      if (cnt_nxt >= needed) begin
        emit    = 1'b1;
        cnt_nxt = 2'd0;
        case (hi)
          midi_rsp_pkg::HI_NOTE_OFF: begin
            kind_nxt = midi_rsp_pkg::KIND_NOTE_OFF;
            num_nxt  = d0_nxt;
            amt_nxt  = {7'd0, d1_nxt};
          end
          midi_rsp_pkg::HI_NOTE_ON: begin
            kind_nxt = (d1_nxt == 7'd0) ? midi_rsp_pkg::KIND_NOTE_OFF
                                        : midi_rsp_pkg::KIND_NOTE_ON;
            num_nxt  = d0_nxt;
            amt_nxt  = {7'd0, d1_nxt};
          end
          midi_rsp_pkg::HI_POLY_AT: begin
            kind_nxt = midi_rsp_pkg::KIND_PRESSURE;
            amt_nxt  = {7'd0, d1_nxt};
          end
          midi_rsp_pkg::HI_CONTROL: begin
            kind_nxt = midi_rsp_pkg::KIND_CONTROL;
            num_nxt  = d0_nxt;
            amt_nxt  = {7'd0, d1_nxt};
          end
          midi_rsp_pkg::HI_PROGRAM: begin
            kind_nxt = midi_rsp_pkg::KIND_PROGRAM;
            num_nxt  = d0_nxt;
          end
          midi_rsp_pkg::HI_CHAN_AT: begin
            kind_nxt = midi_rsp_pkg::KIND_PRESSURE;
            amt_nxt  = {7'd0, d0_nxt};
          end
          default: begin
            kind_nxt = midi_rsp_pkg::KIND_BEND;
            amt_nxt  = {d1_nxt, d0_nxt};
          end
        endcase
      end
    end
  end

  // Result valid: load on advance, clear when taken
  always_comb begin
    if (adv) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= 8'd0;
      cnt_r       <= 2'd0;
      d0_r        <= 7'd0;
      d1_r        <= 7'd0;
      sysex_r     <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        status_r <= status_nxt;
        cnt_r    <= cnt_nxt;
        d0_r     <= d0_nxt;
        d1_r     <= d1_nxt;
        sysex_r  <= sysex_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && emit) begin
      kind_r <= kind_nxt;
      chan_r <= chan_nxt;
      num_r  <= num_nxt;
      amt_r  <= amt_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_msg_kind = kind_r;
  assign out_channel  = chan_r;
  assign out_number   = num_r;
  assign out_amount   = amt_r;

  // Checks on parser behavior
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (kind_r <= midi_rsp_pkg::KIND_BEND))
    else $error("result kind out of range");

  a_note_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == midi_rsp_pkg::KIND_NOTE_ON) |-> (amt_r != 14'd0))
    else $error("note on emitted with zero velocity");

  a_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == midi_rsp_pkg::KIND_PRESSURE ||
                     kind_r == midi_rsp_pkg::KIND_BEND)) |-> (num_r == 7'd0))
    else $error("pressure or bend carries a number");

  a_program_amt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == midi_rsp_pkg::KIND_PROGRAM) |-> (amt_r == 14'd0))
    else $error("program change carries an amount");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd2)
    else $error("data count reached two without a message");

  a_emit_needs_status: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && emit) |=> out_valid_r)
    else $error("completed message not loaded into result register");

endmodule
`default_nettype wire

@@ dv/midi_running_status_parser_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running-status parser core testbench
// Streams directed and random MIDI bytes through the core with random idle
// gaps on both sides, decodes every accepted byte with its own parser model
// and checks each decoded message field by field, in order.
// ----------------------------------------------------------------------------
module midi_running_status_parser_core_tb;

  localparam logic [3:0] HI_BEND      = 4'hE;
  localparam int         RX_ITEMS     = 950;
  localparam int         LONG_HOLD    = 300;
  localparam int         TAIL_CYCLES  = 10;
  localparam int         REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  chan;
    logic [6:0]  number;
    logic [13:0] amount;
  } midi_msg_t;

  typedef struct packed {
    bit         drain_first;
    logic [7:0] data;
  } rx_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_msg_kind;
  logic [3:0]  out_channel;
  logic [6:0]  out_number;
  logic [13:0] out_amount;

  // Parser state mirrored by the testbench
  logic [7:0] status_q;
  logic [1:0] count_q;
  logic [6:0] data_q [2];
  bit         sysex_on;

  rx_req_t   pending_q[$];
  midi_msg_t expected_q[$];
  midi_msg_t new_msg;
  midi_msg_t got_msg;
  midi_msg_t want_msg;

  int  errors;
  int  rx_count;
  bit  drain_next;
  int  tx_gap;
  int  tx_cycle;
  bit  tx_quiet;
  int  rx_hold;
  int  rx_cycle;
  bit  rx_quiet;
  int  results_seen;
  bit  long_hold_done;

  midi_running_status_parser_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_msg_kind (out_msg_kind),
    .out_channel  (out_channel),
    .out_number   (out_number),
    .out_amount   (out_amount)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the mirrored parser by one byte; return 1 when a message completes
  function automatic bit parse_byte(input logic [7:0] b, output midi_msg_t msg);
    logic [3:0] hi;
    int         needed;
    logic [6:0] d0;
    logic [6:0] d1;
    msg = '0;
    if (b >= midi_rsp_pkg::ST_REALTIME) return 1'b0;
    if (b[7]) begin
      if (b == midi_rsp_pkg::ST_SYSEX_SOX) begin
        sysex_on = 1'b1;
      end else if (b == midi_rsp_pkg::ST_SYSEX_EOX) begin
        sysex_on = 1'b0;
      end else if (b > midi_rsp_pkg::ST_SYSEX_SOX) begin
        status_q = 8'h00;
        count_q  = 2'd0;
      end else begin
        status_q = b;
        count_q  = 2'd0;
      end
      return 1'b0;
    end
    if (sysex_on || status_q == 8'h00) return 1'b0;
    // Store the data byte; a full buffer restarts at the first slot
    if (count_q < 2'd2) begin
      data_q[count_q[0]] = b[6:0];
      count_q = count_q + 2'd1;
    end else begin
      data_q[0] = b[6:0];
      count_q = 2'd1;
    end
    hi     = status_q[7:4];
    needed = (hi == midi_rsp_pkg::HI_PROGRAM || hi == midi_rsp_pkg::HI_CHAN_AT) ? 1 : 2;
    if (count_q < needed) return 1'b0;
    count_q  = 2'd0;
    d0       = data_q[0];
    d1       = data_q[1];
    msg.chan = status_q[3:0];
    case (hi)
      midi_rsp_pkg::HI_NOTE_OFF: begin
        msg.kind = midi_rsp_pkg::KIND_NOTE_OFF; msg.number = d0; msg.amount = 14'(d1);
      end
      midi_rsp_pkg::HI_NOTE_ON: begin
        // Zero velocity reads as note off
        msg.kind   = (d1 == 7'd0) ? midi_rsp_pkg::KIND_NOTE_OFF
                                  : midi_rsp_pkg::KIND_NOTE_ON;
        msg.number = d0;
        msg.amount = 14'(d1);
      end
      midi_rsp_pkg::HI_POLY_AT: begin
        msg.kind = midi_rsp_pkg::KIND_PRESSURE; msg.amount = 14'(d1);
      end
      midi_rsp_pkg::HI_CONTROL: begin
        msg.kind = midi_rsp_pkg::KIND_CONTROL; msg.number = d0; msg.amount = 14'(d1);
      end
      midi_rsp_pkg::HI_PROGRAM: begin
        msg.kind = midi_rsp_pkg::KIND_PROGRAM; msg.number = d0;
      end
      midi_rsp_pkg::HI_CHAN_AT: begin
        msg.kind = midi_rsp_pkg::KIND_PRESSURE; msg.amount = 14'(d0);
      end
      default: begin
        msg.kind = midi_rsp_pkg::KIND_BEND; msg.amount = {d1, d0};
      end
    endcase
    return 1'b1;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [6:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 7'h00;
    if (r < 30) return 7'h7F;
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic void report(input string what);
    errors++;
    if (errors <= REPORT_LIMIT) $display("ERROR: %s", what);
  endfunction

  // Queue one request byte; realtime bytes do not count toward the total
  task automatic push_byte(input logic [7:0] b);
    rx_req_t req;
    req.data        = b;
    req.drain_first = drain_next;
    drain_next      = 1'b0;
    pending_q.push_back(req);
    if (b < midi_rsp_pkg::ST_REALTIME) rx_count++;
  endtask

  task automatic push_realtime();
    push_byte(8'($urandom_range(midi_rsp_pkg::ST_REALTIME, 8'hFF)));
  endtask

  task automatic push_directed();
    push_byte(8'h45);                         // data with no status latched
    push_byte({midi_rsp_pkg::HI_NOTE_ON, 4'h0});
    push_byte(8'h3C); push_byte(8'h64);
    push_byte(8'h3C); push_byte(8'h00);       // running status, zero velocity
    push_byte({midi_rsp_pkg::HI_NOTE_OFF, 4'hF});
    push_byte(8'h7F); push_byte(8'hF8); push_byte(8'h7F);
    push_byte({midi_rsp_pkg::HI_POLY_AT, 4'h3});
    push_byte(8'h40); push_byte(8'h11);
    push_byte({midi_rsp_pkg::HI_CONTROL, 4'h5});
    push_byte(8'h07); push_byte(8'h00);
    push_byte({midi_rsp_pkg::HI_PROGRAM, 4'h9}); push_byte(8'h7F);
    push_byte({midi_rsp_pkg::HI_CHAN_AT, 4'hA}); push_byte(8'h00);
    push_byte({HI_BEND, 4'h2});
    push_byte(8'h00); push_byte(8'h40); push_byte(8'h7F); push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(midi_rsp_pkg::ST_SYSEX_EOX);    // stray end of SysEx
    push_byte(midi_rsp_pkg::ST_SYSEX_SOX);    // channel status inside SysEx
    push_byte({midi_rsp_pkg::HI_NOTE_ON, 4'h1}); push_byte(8'h20);
    push_byte(midi_rsp_pkg::ST_SYSEX_EOX);
    push_byte(8'h20); push_byte(8'h30);
    push_byte(8'hF3); push_byte(8'h10);       // system common drops status
  endtask

  task automatic push_random();
    logic [3:0] hi;
    int         r;
    int         n;
    bit         drain_set;
    drain_set = 1'b0;
    while (rx_count < RX_ITEMS) begin
      // Pause the sender once, halfway through, until the core is empty
      if (!drain_set && rx_count >= RX_ITEMS / 2) begin
        drain_next = 1'b1;
        drain_set  = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Well-formed channel message, often under running status
        hi = 4'($urandom_range(midi_rsp_pkg::HI_NOTE_OFF, HI_BEND));
        if ($urandom_range(0, 99) < 70) push_byte({hi, 4'($urandom_range(0, 15))});
        else hi = status_q[7:4];
        n = (hi == midi_rsp_pkg::HI_PROGRAM || hi == midi_rsp_pkg::HI_CHAN_AT) ? 1 : 2;
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) push_realtime();
          push_byte({1'b0, pick_data()});
        end
      end else if (r < 78) begin
        push_byte(midi_rsp_pkg::ST_SYSEX_SOX);
        repeat ($urandom_range(0, 5)) push_byte({1'b0, pick_data()});
        if ($urandom_range(0, 4) != 0) push_byte(midi_rsp_pkg::ST_SYSEX_EOX);
      end else if (r < 84) begin
        push_byte(8'($urandom_range(8'hF1, 8'hF6)));
      end else if (r < 87) begin
        push_byte(midi_rsp_pkg::ST_SYSEX_EOX);
      end else if (r < 91) begin
        // Status and a single data byte: a broken message unless the status takes one
        push_byte({4'($urandom_range(midi_rsp_pkg::HI_NOTE_OFF, HI_BEND)),
                   4'($urandom_range(0, 15))});
        push_byte({1'b0, pick_data()});
      end else if (r < 94) begin
        push_realtime();
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Sender: present queued requests with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (parse_byte(in_rx_byte, new_msg)) expected_q.push_back(new_msg);
      end
      tx_cycle++;
      if (tx_cycle % 100 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_q[0].drain_first && expected_q.size() != 0) begin
          // Hold until every decoded message has come out
          in_valid <= 1'b0;
        end else begin
          in_valid   <= 1'b1;
          in_rx_byte <= pending_q[0].data;
          void'(pending_q.pop_front());
          tx_gap = pick_gap(tx_quiet);
        end
      end
    end
  end

  // Receiver: check each result against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        got_msg = '{out_msg_kind, out_channel, out_number, out_amount};
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result kind=%0d ch=%0d num=%0d amt=%0d",
                           got_msg.kind, got_msg.chan, got_msg.number, got_msg.amount));
        end else begin
          want_msg = expected_q.pop_front();
          if (got_msg !== want_msg)
            report($sformatf({"result %0d: expected kind=%0d ch=%0d num=%0d amt=%0d,",
                              " got kind=%0d ch=%0d num=%0d amt=%0d"},
                             results_seen, want_msg.kind, want_msg.chan, want_msg.number,
                             want_msg.amount, got_msg.kind, got_msg.chan, got_msg.number,
                             got_msg.amount));
        end
      end
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 150) begin
        // Long hold-off so the core fills and drops in_ready
        long_hold_done = 1'b1;
        rx_hold = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (rx_quiet || $urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        rx_hold = pick_gap(1'b0);
        out_ready <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    status_q = 8'h00;
    count_q  = 2'd0;
    data_q   = '{7'h00, 7'h00};
    sysex_on = 1'b0;
    push_directed();
    push_random();
    // The generator read the mirror for running status; restore reset state
    status_q = 8'h00;
    count_q  = 2'd0;
    data_q   = '{7'h00, 7'h00};
    sysex_on = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) report("expected results left over at end");
    if (errors == 0) begin
      $display("midi_running_status_parser_core_tb: done, clean");
    end else begin
      $display("midi_running_status_parser_core_tb: done, errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2_000_000;
    $display("midi_running_status_parser_core_tb: done, errors");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/midi_rsp_pkg.sv
hw/rtl/midi_running_status_parser_core.sv
dv/midi_running_status_parser_core_tb.sv
